FILE: hdl/assert_macros.svh
// Assertion macros used by the checker module of the bias corrector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds through reset.
`define ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/imubc_pkg.sv
// Package: widths, codes and types of the IMU bias calibration corrector.
`timescale 1ns / 1ps
`default_nettype none

package imubc_pkg;

  localparam int SETS_PER_PASS = 50;
  localparam int NUM_SENSORS   = 3;
  localparam int NUM_ENTRIES   = 3 * NUM_SENSORS;

  localparam int RAW_W       = 16;
  localparam int Q8_W        = 24;
  localparam int GAIN_W      = 24;
  localparam int OUT_W       = 32;
  localparam int CNT_W       = 6;
  localparam int IDX_W       = 2;
  localparam int HEALTH_W    = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 208;

  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_GAIN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_GAIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_BIAS_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_BIAS_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_BIAS_Z = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_LIMIT  = 3'd5;

  localparam logic [GAIN_W-1:0] GYRO_GAIN_RST   = 24'd4575;
  localparam logic [GAIN_W-1:0] ACCEL_GAIN_RST  = 24'd20091;
  localparam logic [RAW_W-1:0]  DRIFT_LIMIT_RST = 16'd800;

  typedef logic signed [RAW_W-1:0] raw_t;
  typedef logic signed [Q8_W-1:0]  q8_t;
  typedef logic signed [OUT_W-1:0] out_t;

  typedef enum logic [1:0] {
    PH_PASS1 = 2'd0,
    PH_PASS2 = 2'd1,
    PH_DONE  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [HEALTH_W-1:0] accel_ok;
    logic [HEALTH_W-1:0] gyro_ok;
    logic                sensors_ok;
    phase_t              phase;
  } cal_status_t;

endpackage

`default_nettype wire

FILE: hdl/imubc_calib.sv
// Calibration state: per-axis averages, pass sequencing and health decisions.
`timescale 1ns / 1ps
`default_nettype none

module imubc_calib (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            step,
  input  wire  [imubc_pkg::IDX_W-1:0]    idx,
  input  imubc_pkg::raw_t                gyro_raw [3],
  input  imubc_pkg::raw_t                accel_raw [3],
  input  wire  [imubc_pkg::RAW_W-1:0]    drift_limit,
  output imubc_pkg::cal_status_t         stat_nxt,
  output logic                           corr_en,
  output imubc_pkg::q8_t                 gyro_bias [3]
);

  localparam int N = imubc_pkg::NUM_ENTRIES;

  function automatic imubc_pkg::q8_t ema(imubc_pkg::q8_t avg, imubc_pkg::raw_t raw);
    logic signed [33:0] v;
    logic signed [25:0] sh;
    v  = 34'(avg) * 34'sd179 + 34'(raw) * 34'sd19712 + 34'sd128;
    sh = v[33:8];
    if (sh > 26'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (sh < -26'sd8388608) begin
      return 24'sh800000;
    end
    return sh[23:0];
  endfunction

  imubc_pkg::q8_t gavg_r [N];
  imubc_pkg::q8_t gavg_nxt [N];
  imubc_pkg::q8_t aavg_r [N];
  imubc_pkg::q8_t aavg_nxt [N];
  imubc_pkg::q8_t fpm_r [N];
  imubc_pkg::q8_t fpm_nxt [N];
  imubc_pkg::q8_t gupd [N];
  imubc_pkg::q8_t aupd [N];
  imubc_pkg::q8_t mean [N];
  imubc_pkg::q8_t g_sel [3];
  imubc_pkg::q8_t a_sel [3];
  imubc_pkg::q8_t g_ema [3];
  imubc_pkg::q8_t a_ema [3];

  logic [imubc_pkg::CNT_W-1:0]    cnt_r, cnt_nxt, cnt_inc;
  imubc_pkg::phase_t              phase_r, phase_nxt;
  logic [imubc_pkg::HEALTH_W-1:0] gok_r, gok_nxt, aok_r, aok_nxt;
  logic [imubc_pkg::HEALTH_W-1:0] g_pass, a_nz;
  logic                           have_r, have_nxt;
  logic                           idx_ok, idx_last, cal_step;

  assign idx_ok   = ({1'b0, idx} < 3'(imubc_pkg::NUM_SENSORS));
  assign idx_last = (idx == imubc_pkg::IDX_W'(imubc_pkg::NUM_SENSORS - 1));
  assign cal_step = step && idx_ok && (phase_r != imubc_pkg::PH_DONE);
  assign cnt_inc  = cnt_r + 1'b1;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      g_sel[a] = '0;
      a_sel[a] = '0;
      for (int i = 0; i < imubc_pkg::NUM_SENSORS; i++) begin
        if (idx == imubc_pkg::IDX_W'(i)) begin
          g_sel[a] = gavg_r[i * 3 + a];
          a_sel[a] = aavg_r[i * 3 + a];
        end
      end
      g_ema[a] = ema(g_sel[a], gyro_raw[a]);
      a_ema[a] = ema(a_sel[a], accel_raw[a]);
    end
  end

  always_comb begin
    for (int i = 0; i < imubc_pkg::NUM_SENSORS; i++) begin
      for (int a = 0; a < 3; a++) begin
        gupd[i * 3 + a] = (idx == imubc_pkg::IDX_W'(i)) ? g_ema[a] : gavg_r[i * 3 + a];
        aupd[i * 3 + a] = (idx == imubc_pkg::IDX_W'(i)) ? a_ema[a] : aavg_r[i * 3 + a];
      end
    end
  end

  // drift and mean checks against the first-pass mean, plus accel nonzero flags
  always_comb begin
    logic signed [24:0] d;
    logic signed [24:0] s;
    logic        [24:0] ad;
    g_pass = '0;
    a_nz   = '0;
    for (int i = 0; i < imubc_pkg::NUM_SENSORS; i++) begin
      g_pass[i] = 1'b1;
      for (int a = 0; a < 3; a++) begin
        d  = 25'(gupd[i * 3 + a]) - 25'(fpm_r[i * 3 + a]);
        s  = 25'(gupd[i * 3 + a]) + 25'(fpm_r[i * 3 + a]);
        ad = d[24] ? 25'(-d) : 25'(d);
        if (!(ad < {1'b0, drift_limit, 8'b0}) || (s == '0)) begin
          g_pass[i] = 1'b0;
        end
        mean[i * 3 + a] = s[24:1];
        if (aupd[i * 3 + a] != '0) begin
          a_nz[i] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= imubc_pkg::PH_PASS1;
      cnt_r   <= '0;
      gok_r   <= '0;
      aok_r   <= '0;
      have_r  <= 1'b0;
      for (int k = 0; k < N; k++) begin
        gavg_r[k] <= '0;
        aavg_r[k] <= '0;
        fpm_r[k]  <= '0;
      end
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      gok_r   <= gok_nxt;
      aok_r   <= aok_nxt;
      have_r  <= have_nxt;
      for (int k = 0; k < N; k++) begin
        gavg_r[k] <= gavg_nxt[k];
        aavg_r[k] <= aavg_nxt[k];
        fpm_r[k]  <= fpm_nxt[k];
      end
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    gok_nxt   = gok_r;
    aok_nxt   = aok_r;
    have_nxt  = have_r;
    gavg_nxt  = gavg_r;
    aavg_nxt  = aavg_r;
    fpm_nxt   = fpm_r;
    if (cal_step) begin
      gavg_nxt = gupd;
      aavg_nxt = aupd;
      if (idx_last) begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= imubc_pkg::CNT_W'(imubc_pkg::SETS_PER_PASS)) begin
          cnt_nxt = '0;
          unique case (phase_r)
            imubc_pkg::PH_PASS1: begin
              fpm_nxt   = gupd;
              for (int k = 0; k < N; k++) begin
                gavg_nxt[k] = '0;
              end
              phase_nxt = imubc_pkg::PH_PASS2;
            end
            imubc_pkg::PH_PASS2: begin
              for (int i = 0; i < imubc_pkg::NUM_SENSORS; i++) begin
                for (int a = 0; a < 3; a++) begin
                  gavg_nxt[i * 3 + a] = g_pass[i] ? mean[i * 3 + a] : '0;
                end
              end
              for (int k = 0; k < N; k++) begin
                aavg_nxt[k] = '0;
              end
              gok_nxt   = gok_r | g_pass;
              aok_nxt   = aok_r | a_nz;
              have_nxt  = ((gok_r | g_pass) != '0) && ((aok_r | a_nz) != '0);
              phase_nxt = imubc_pkg::PH_DONE;
            end
            default: begin
              phase_nxt = phase_r;
            end
          endcase
        end
      end
    end
  end

  assign stat_nxt.phase      = phase_nxt;
  assign stat_nxt.sensors_ok = have_nxt;
  assign stat_nxt.gyro_ok    = gok_nxt;
  assign stat_nxt.accel_ok   = aok_nxt;

  assign corr_en = step && (idx == '0) && (phase_r == imubc_pkg::PH_DONE);

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      gyro_bias[a] = gavg_r[a];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/imubc_correct.sv
// Correction datapath: bias subtract, gain multiply, round and saturate.
`timescale 1ns / 1ps
`default_nettype none

module imubc_correct (
  input  wire                              en,
  input  imubc_pkg::raw_t                  gyro_raw [3],
  input  imubc_pkg::raw_t                  accel_raw [3],
  input  imubc_pkg::q8_t                   gyro_bias [3],
  input  imubc_pkg::raw_t                  accel_bias [3],
  input  wire  [imubc_pkg::GAIN_W-1:0]     gyro_gain,
  input  wire  [imubc_pkg::GAIN_W-1:0]     accel_gain,
  output imubc_pkg::out_t                  rate [3],
  output imubc_pkg::out_t                  acc [3]
);

  function automatic imubc_pkg::out_t sat32(logic signed [33:0] v);
    if (v > 34'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -34'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  always_comb begin
    logic signed [24:0] dg;
    logic signed [16:0] da;
    logic signed [49:0] pg;
    logic signed [41:0] pa;
    for (int a = 0; a < 3; a++) begin
      dg = 25'($signed({gyro_raw[a], 8'b0})) - 25'(gyro_bias[a]);
      da = 17'(accel_raw[a]) - 17'(accel_bias[a]);
      pg = 50'(dg) * 50'($signed({1'b0, gyro_gain}));
      pa = 42'(da) * 42'($signed({1'b0, accel_gain}));
      pg = pg + 50'sd32768;
      pa = pa + 42'sd128;
      rate[a] = en ? sat32(pg[49:16]) : '0;
      acc[a]  = en ? sat32(pa[41:8]) : '0;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/imu_bias_calibration_corrector.sv
// Top level: IMU bias calibration and correction with stream in and out.
//
// Input beats carry one raw sample set (three gyro and three accel axes) of
// one sensor instance, selected by in_tuser. Each accepted beat yields
// exactly one output beat holding the calibration phase, the health bits and
// the six corrected values (zero unless calibrated and instance 0).
// An accepted beat passes through the input register and then the result
// register before out_tvalid shows it. Throughput: one beat per cycle while
// out_tready is high; the per-instance average update and the gain
// multipliers all sit in the single stage between the two registers.
// When the receiver holds out_tready low, the result register holds and the
// input register can still take one more beat; in_tready then drops.
// Configuration writes through cfg_wr_en take effect at the next edge and
// must be made while no beat is in flight.
// Reset (rst_n low, synchronous) clears all averages, the pass counter, the
// phase and health bits, both valid flags, and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module imu_bias_calibration_corrector (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  // gyro_raw_x, gyro_raw_y, gyro_raw_z, accel_raw_x, accel_raw_y, accel_raw_z
  input  wire  [imubc_pkg::IN_TDATA_W-1:0]     in_tdata,
  // sensor_index
  input  wire  [imubc_pkg::IDX_W-1:0]          in_tuser,
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  // phase, sensors_ok, gyro_health, accel_health, rate_x, rate_y, rate_z,
  // acc_x, acc_y, acc_z, zero pad
  output logic [imubc_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  wire                                  cfg_wr_en,
  input  wire  [imubc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [imubc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int RW = imubc_pkg::RAW_W;

  logic [imubc_pkg::GAIN_W-1:0] gyro_gain_r, accel_gain_r;
  logic [RW-1:0]                drift_limit_r;
  imubc_pkg::raw_t              accel_bias_r [3];

  logic                         in_valid_r, in_valid_nxt;
  logic [imubc_pkg::IDX_W-1:0]  in_idx_r;
  imubc_pkg::raw_t              in_g_r [3];
  imubc_pkg::raw_t              in_a_r [3];

  logic                             out_valid_r, out_valid_nxt;
  logic [imubc_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic                   adv, step, in_take, corr_en;
  imubc_pkg::cal_status_t stat_nxt;
  imubc_pkg::q8_t         gyro_bias [3];
  imubc_pkg::out_t        rate [3];
  imubc_pkg::out_t        acc [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gyro_gain_r     <= imubc_pkg::GYRO_GAIN_RST;
      accel_gain_r    <= imubc_pkg::ACCEL_GAIN_RST;
      drift_limit_r   <= imubc_pkg::DRIFT_LIMIT_RST;
      accel_bias_r[0] <= '0;
      accel_bias_r[1] <= '0;
      accel_bias_r[2] <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        imubc_pkg::CFG_GYRO_GAIN:    gyro_gain_r     <= cfg_wdata;
        imubc_pkg::CFG_ACCEL_GAIN:   accel_gain_r    <= cfg_wdata;
        imubc_pkg::CFG_ACCEL_BIAS_X: accel_bias_r[0] <= cfg_wdata[RW-1:0];
        imubc_pkg::CFG_ACCEL_BIAS_Y: accel_bias_r[1] <= cfg_wdata[RW-1:0];
        imubc_pkg::CFG_ACCEL_BIAS_Z: accel_bias_r[2] <= cfg_wdata[RW-1:0];
        imubc_pkg::CFG_DRIFT_LIMIT:  drift_limit_r   <= cfg_wdata[RW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign adv       = !out_valid_r || out_tready;
  assign step      = in_valid_r && adv;
  assign in_tready = !in_valid_r || adv;
  assign in_take   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (adv) begin
      in_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_idx_r <= in_tuser;
      for (int a = 0; a < 3; a++) begin
        in_g_r[a] <= in_tdata[a * RW +: RW];
        in_a_r[a] <= in_tdata[(a + 3) * RW +: RW];
      end
    end
    if (step) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  imubc_calib u_calib (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .idx         (in_idx_r),
    .gyro_raw    (in_g_r),
    .accel_raw   (in_a_r),
    .drift_limit (drift_limit_r),
    .stat_nxt    (stat_nxt),
    .corr_en     (corr_en),
    .gyro_bias   (gyro_bias)
  );

  imubc_correct u_correct (
    .en         (corr_en),
    .gyro_raw   (in_g_r),
    .accel_raw  (in_a_r),
    .gyro_bias  (gyro_bias),
    .accel_bias (accel_bias_r),
    .gyro_gain  (gyro_gain_r),
    .accel_gain (accel_gain_r),
    .rate       (rate),
    .acc        (acc)
  );

  assign out_tdata_nxt = {7'b0, acc[2], acc[1], acc[0], rate[2], rate[1], rate[0],
                          stat_nxt.accel_ok, stat_nxt.gyro_ok, stat_nxt.sensors_ok,
                          stat_nxt.phase};

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

FILE: hdl/imubc_checker.sv
// Port checker for the bias corrector and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module imubc_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                out_tvalid,
  input wire                                out_tready,
  input wire [imubc_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  logic out_stall, uncal;

  assign out_stall = out_tvalid && !out_tready;
  assign uncal     = out_tvalid && (out_tdata[1:0] != 2'd2);

  `ASSERT_NXT(a_hold_stalled, clk, rst_n, out_stall, out_tvalid && $stable(out_tdata), "stalled output beat changed")
  `ASSERT_NXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_tvalid, "output valid right after reset")
  `ASSERT_IMP(a_phase_code, clk, rst_n, out_tvalid, out_tdata[1:0] != 2'd3, "phase code out of range")
  `ASSERT_IMP(a_zero_uncal, clk, rst_n, uncal, out_tdata[200:9] == '0, "nonzero values before calibration")
  `ASSERT_IMP(a_ok_needs_health, clk, rst_n, out_tvalid && out_tdata[2], (out_tdata[5:3] != 3'd0) && (out_tdata[8:6] != 3'd0), "sensors_ok without healthy instances")

endmodule

bind imu_bias_calibration_corrector imubc_checker u_chk (.*);

`default_nettype wire
